[rtl/u8deacc_pkg.sv]
// Shared types, constants and byte mapping functions for the UTF-8 Latin deaccent block.
package u8deacc_pkg;

  localparam logic [7:0] LeadC3    = 8'hC3;
  localparam logic [7:0] LeadC4    = 8'hC4;
  localparam logic [7:0] LeadC5    = 8'hC5;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] CaseStep  = 8'h20;

  // Lead byte held from the previous item
  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_C3   = 2'd1,
    LEAD_C4   = 2'd2,
    LEAD_C5   = 2'd3
  } lead_e;

  // Second byte after 0xC3: fixed range ladder
  function automatic logic [7:0] map_c3(input logic [7:0] b);
    logic [7:0] c;
    if (b >= 8'd128 && b <= 8'd134)      c = "A";
    else if (b == 8'd135)                c = "C";
    else if (b >= 8'd136 && b <= 8'd139) c = "E";
    else if (b >= 8'd140 && b <= 8'd143) c = "I";
    else if (b == 8'd144)                c = "D";
    else if (b == 8'd145)                c = "N";
    else if (b >= 8'd146 && b <= 8'd150) c = "O";
    else if (b >= 8'd153 && b <= 8'd156) c = "U";
    else if (b == 8'd157)                c = "Y";
    else if (b == 8'd159)                c = "s";
    else if (b >= 8'd160 && b <= 8'd166) c = "a";
    else if (b == 8'd167)                c = "c";
    else if (b >= 8'd168 && b <= 8'd171) c = "e";
    else if (b >= 8'd172 && b <= 8'd175) c = "i";
    else if (b == 8'd177)                c = "n";
    else if (b >= 8'd178 && b <= 8'd182) c = "o";
    else if (b >= 8'd185 && b <= 8'd188) c = "u";
    else if (b == 8'd189 || b == 8'd191) c = "y";
    else                                 c = SpaceChar;
    return c;
  endfunction

  // Second byte after 0xC4: runs A, C, D, E from 128, all starting on even codes
  function automatic logic [7:0] map_c4(input logic [7:0] b);
    logic [7:0] base;
    logic       hit;
    hit  = 1'b1;
    base = SpaceChar;
    if (b < 8'd128)      hit = 1'b0;
    else if (b < 8'd134) base = "A";
    else if (b < 8'd142) base = "C";
    else if (b < 8'd146) base = "D";
    else if (b < 8'd156) base = "E";
    else                 hit = 1'b0;
    if (!hit) return SpaceChar;
    return b[0] ? base + CaseStep : base;
  endfunction

  // Second byte after 0xC5: runs from 131 with gaps; case follows offset parity
  function automatic logic [7:0] map_c5(input logic [7:0] b);
    logic [7:0] base;
    logic       start_odd;
    logic       hit;
    hit       = 1'b1;
    base      = SpaceChar;
    start_odd = 1'b0;
    if (b < 8'd131)      hit = 1'b0;
    else if (b < 8'd137) begin
      base      = "N";
      start_odd = 1'b1;
    end
    else if (b < 8'd140) hit = 1'b0;
    else if (b < 8'd146) base = "O";
    else if (b < 8'd148) hit = 1'b0;
    else if (b < 8'd154) base = "R";
    else if (b < 8'd162) base = "S";
    else if (b < 8'd168) base = "T";
    else if (b < 8'd180) base = "U";
    else if (b < 8'd182) hit = 1'b0;
    else if (b < 8'd185) base = "Y";
    else if (b < 8'd191) begin
      // Z run starts on an odd code
      base      = "Z";
      start_odd = 1'b1;
    end
    else                 hit = 1'b0;
    if (!hit) return SpaceChar;
    return (b[0] ^ start_odd) ? base + CaseStep : base;
  endfunction

endpackage

[rtl/utf8_latin_deaccent.sv]
// An accepted byte passes the input register, the mapping ladder, then the result register.
// Throughput: one byte per cycle while m_axis_tready does not stall the output.
// Lead bytes 0xC3..0xC5 with no lead held give no output; the next byte gives the mapped char.
// Reset (rst_ni low, asynchronous) empties both registers and clears the held lead.
// tlast on an input item drops any held lead once that item is handled.
module utf8_latin_deaccent (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] out_char
);

  logic                 in_valid_q, in_valid_d;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;
  u8deacc_pkg::lead_e   lead_q, lead_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_char_q, out_char_d;
  logic                 proc_fire;
  logic                 emit;
  logic                 s_fire;

  // Stage handshake: input register moves when the result register is free or drains
  assign proc_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = s_fire ? 1'b1 : (proc_fire ? 1'b0 : in_valid_q);
  end

  // Decode held lead and map the current byte
  always_comb begin
    lead_d     = lead_q;
    emit       = 1'b0;
    out_char_d = in_byte_q;
    unique case (lead_q)
      u8deacc_pkg::LEAD_C3: begin
        emit       = 1'b1;
        out_char_d = u8deacc_pkg::map_c3(in_byte_q);
        lead_d     = u8deacc_pkg::LEAD_NONE;
      end
      u8deacc_pkg::LEAD_C4: begin
        emit       = 1'b1;
        out_char_d = u8deacc_pkg::map_c4(in_byte_q);
        lead_d     = u8deacc_pkg::LEAD_NONE;
      end
      u8deacc_pkg::LEAD_C5: begin
        emit       = 1'b1;
        out_char_d = u8deacc_pkg::map_c5(in_byte_q);
        lead_d     = u8deacc_pkg::LEAD_NONE;
      end
      u8deacc_pkg::LEAD_NONE: begin
        if (in_byte_q == u8deacc_pkg::LeadC3)      lead_d = u8deacc_pkg::LEAD_C3;
        else if (in_byte_q == u8deacc_pkg::LeadC4) lead_d = u8deacc_pkg::LEAD_C4;
        else if (in_byte_q == u8deacc_pkg::LeadC5) lead_d = u8deacc_pkg::LEAD_C5;
        else emit = 1'b1;
      end
      default: begin
        lead_d = u8deacc_pkg::LEAD_NONE;
      end
    endcase
    if (in_last_q) lead_d = u8deacc_pkg::LEAD_NONE;
  end

  // Result register valid
  always_comb begin
    if (proc_fire) out_valid_d = emit;
    else if (m_axis_tready) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lead_q      <= u8deacc_pkg::LEAD_NONE;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (proc_fire) lead_q <= lead_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (proc_fire && emit) out_char_q <= out_char_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;

`ifndef SYNTHESIS
  // A lead byte with nothing held becomes the held lead unless it is the last item
  a_lead_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && lead_q == u8deacc_pkg::LEAD_NONE && !in_last_q &&
     (in_byte_q == u8deacc_pkg::LeadC3 || in_byte_q == u8deacc_pkg::LeadC4 ||
      in_byte_q == u8deacc_pkg::LeadC5))
    |=> (lead_q != u8deacc_pkg::LEAD_NONE && !out_valid_q))
    else $error("lead byte not held or produced output");

  // Last item always leaves no lead pending
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && in_last_q) |=> lead_q == u8deacc_pkg::LEAD_NONE)
    else $error("lead still pending after last item");

  // A byte following a held lead always yields a char
  a_second_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && lead_q != u8deacc_pkg::LEAD_NONE) |=> out_valid_q)
    else $error("second byte produced no output");
`endif

endmodule
